// ----- design/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpm_pkg: shared constants and types for the battery power mode monitor
// Register indexes, mode codes, request codes and divider handshake types.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int unsigned AdcBits = 12;
  localparam int unsigned MvW     = 14;
  localparam int unsigned RtW     = 20;
  localparam int unsigned DivW    = 48;

  localparam logic [2:0] RegMin  = 3'd0;
  localparam logic [2:0] RegMax  = 3'd1;
  localparam logic [2:0] RegLow  = 3'd2;
  localparam logic [2:0] RegCrit = 3'd3;
  localparam logic [2:0] RegDiv  = 3'd4;

  localparam logic [2:0] ModeNormal   = 3'd0;
  localparam logic [2:0] ModeEconomy  = 3'd1;
  localparam logic [2:0] ModeLow      = 3'd2;
  localparam logic [2:0] ModeCritical = 3'd3;
  localparam logic [2:0] ModeShutdown = 3'd4;

  localparam logic [1:0] ReqNone = 2'd0;
  localparam logic [1:0] ReqSafe = 2'd1;
  localparam logic [1:0] ReqStop = 2'd2;
  localparam logic [1:0] ReqIdle = 2'd3;

  localparam logic [DivW-1:0] MvDen = DivW'(((64'd1 << AdcBits) - 64'd1) * 64'd256);

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

endpackage

// ----- design/bpm_div.sv -----
// ----------------------------------------------------------------------------
// bpm_div: bit-serial restoring divider
// One quotient bit per cycle, numerator shifted out from the top.
// ----------------------------------------------------------------------------
module bpm_div
  import bpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivW-1:0] num_q, num_d, quo_q, quo_d, den_q, den_d;
  logic [DivW:0]   rem_q, rem_d, trial;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DivW-1:0], num_q[DivW-1]} - {1'b0, den_q};
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DivW-2:0], 1'b0};
      if (!trial[DivW]) begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-1:0], num_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- design/battery_power_mode_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_power_mode_monitor: battery voltage watcher with power modes
// Gates samples by interval, derives voltage, percent, mode and runtime.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: adc_raw, now_ms
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result fields
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// A gated-off beat goes from StIdle straight to StOut. A processed beat uses
// the shared 48-step bit-serial divider: one pass for millivolts, one for
// percent when the voltage lies strictly between min and max, one for runtime
// when an estimate is due, plus the StRtMul and StFin steps. One beat is in
// work at a time; the result register holds a beat while the next input is
// taken, and a new result waits in StOut while the previous one is not yet
// taken. Reset sets state, config and status registers, not sample or result data.
// ----------------------------------------------------------------------------
module battery_power_mode_monitor
  import bpm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // adc_raw[11:0], now_ms[43:12], zero fill
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // sampled, voltage_mv, percent, charging,
                                       // mode, mode_changed, speed_cap_pct,
                                       // led_level, robot_request, runtime_min,
                                       // low_flag, crit_flag, zero fill
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [13:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle, StMv, StPct, StRtMul, StRt, StFin, StOut
  } state_e;

  state_e st_q;
  logic [MvW-1:0] min_q, max_q, low_q, crit_q;
  logic [10:0]    dq8_q;
  logic [31:0]    last_q, ref_t_q, now_q;
  logic [14:0]    intv_q;
  logic [2:0]     mode_q;
  logic           lowf_q, critf_q, chg_q, samp_q, chgd_q;
  logic [MvW-1:0] prev_q, ref_v_q, v_q;
  logic [RtW-1:0] rt_q;
  logic [6:0]     spd_q, pct_q;
  logic [7:0]     led_q;
  logic [1:0]     req_q;
  logic [11:0]    adc_q;
  logic [DivW-1:0] prod_q, den_q;
  logic           obusy_q;
  logic [71:0]    out_q;

  div_req_t dreq;
  div_rsp_t drsp;

  bpm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [MvW-1:0] vmv;
  logic [2:0]     m_new;
  logic [31:0]    dt;
  assign vmv = (drsp.quo > DivW'(16383)) ? 14'h3FFF : drsp.quo[MvW-1:0];
  assign dt  = now_q - ref_t_q;

  always_comb begin
    m_new = ModeNormal;
    if (v_q <= min_q) m_new = ModeShutdown;
    else if (v_q <= crit_q) m_new = ModeCritical;
    else if (v_q <= low_q) m_new = ModeLow;
    else if (pct_q < 7'd30) m_new = ModeEconomy;
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = obusy_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    dreq = '0;
    if (st_q == StMv && !samp_q) begin
      dreq.start = 1'b1;
      dreq.num   = DivW'(adc_q) * DivW'(3300) * DivW'(dq8_q);
      dreq.den   = MvDen;
    end else if (st_q == StRt && !samp_q) begin
      dreq.start = 1'b1;
      dreq.num   = prod_q;
      dreq.den   = den_q;
    end else if (st_q == StPct && !samp_q && v_q < max_q && v_q > min_q) begin
      dreq.start = 1'b1;
      dreq.num   = DivW'(v_q - min_q) * DivW'(100);
      dreq.den   = DivW'(max_q - min_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      min_q <= 14'd6000; max_q <= 14'd8400; low_q <= 14'd6800;
      crit_q <= 14'd6400; dq8_q <= 11'd512;
      last_q <= '0; intv_q <= 15'd2000; mode_q <= ModeNormal;
      lowf_q <= 1'b0; critf_q <= 1'b0; chg_q <= 1'b0;
      prev_q <= '0; ref_v_q <= '0; ref_t_q <= '0; rt_q <= '0;
      spd_q <= 7'd100; led_q <= 8'd255;
      obusy_q <= 1'b0; samp_q <= 1'b0;
      chgd_q <= 1'b0; req_q <= ReqNone; v_q <= '0; pct_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMin:  min_q  <= cfg_data_i;
          RegMax:  max_q  <= cfg_data_i;
          RegLow:  low_q  <= cfg_data_i;
          RegCrit: crit_q <= cfg_data_i;
          RegDiv:  dq8_q  <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (obusy_q && m_axis_tready) obusy_q <= 1'b0;
      case (st_q)
        StIdle: if (s_axis_tvalid) begin
          adc_q <= s_axis_tdata[11:0];
          now_q <= s_axis_tdata[43:12];
          samp_q <= 1'b0;
          if ((s_axis_tdata[43:12] - last_q) > {17'd0, intv_q}) st_q <= StMv;
          else begin
            v_q <= '0; pct_q <= '0; chgd_q <= 1'b0; req_q <= ReqNone;
            st_q <= StOut;
          end
        end
        StMv: begin
          if (samp_q && drsp.done) begin
            v_q <= vmv;
            samp_q <= 1'b0;
            st_q <= StPct;
          end else samp_q <= 1'b1;
        end
        StPct: begin
          if (!samp_q) begin
            if (prev_q > 14'd0 && {1'b0, v_q} > {1'b0, prev_q} + 15'd100) chg_q <= 1'b1;
            else if ({1'b0, v_q} + 15'd50 < {1'b0, prev_q}) chg_q <= 1'b0;
            prev_q <= v_q;
            if (v_q >= max_q) begin
              pct_q <= 7'd100; st_q <= StRtMul;
            end else if (v_q <= min_q) begin
              pct_q <= 7'd0; st_q <= StRtMul;
            end else samp_q <= 1'b1;
          end else if (drsp.done) begin
            pct_q <= drsp.quo[6:0];
            samp_q <= 1'b0;
            st_q <= StRtMul;
          end
        end
        StRtMul: begin
          prod_q <= DivW'(v_q - crit_q) * DivW'(dt);
          den_q  <= DivW'(ref_v_q - v_q) * DivW'(60000);
          if (m_new != mode_q) begin
            chgd_q <= 1'b1;
            mode_q <= m_new;
            case (m_new)
              ModeNormal: if (lowf_q || critf_q) begin
                lowf_q <= 1'b0; critf_q <= 1'b0;
                spd_q <= 7'd100; led_q <= 8'd255; intv_q <= 15'd2000;
                req_q <= ReqIdle;
              end else req_q <= ReqNone;
              ModeEconomy: begin
                spd_q <= 7'd70; led_q <= 8'd128; intv_q <= 15'd5000;
                req_q <= ReqNone;
              end
              ModeLow: begin
                lowf_q <= 1'b1;
                spd_q <= 7'd40; led_q <= 8'd64; intv_q <= 15'd10000;
                req_q <= ReqSafe;
              end
              ModeCritical: begin
                critf_q <= 1'b1;
                spd_q <= 7'd20; led_q <= 8'd32; intv_q <= 15'd30000;
                req_q <= ReqSafe;
              end
              default: req_q <= ReqStop;
            endcase
          end else begin
            chgd_q <= 1'b0; req_q <= ReqNone;
          end
          if (ref_t_q != 32'd0 && ref_v_q != 14'd0 && dt > 32'd60000 && ref_v_q > v_q) begin
            if (v_q > crit_q) st_q <= StRt;
            else begin
              rt_q <= '0; st_q <= StFin;
            end
          end else st_q <= StFin;
        end
        StRt: begin
          if (samp_q && drsp.done) begin
            rt_q <= (drsp.quo > DivW'(1048575)) ? 20'hFFFFF : drsp.quo[RtW-1:0];
            samp_q <= 1'b0;
            st_q <= StFin;
          end else samp_q <= 1'b1;
        end
        StFin: begin
          if (dt > 32'd60000) begin
            ref_v_q <= v_q; ref_t_q <= now_q;
          end
          last_q <= now_q;
          samp_q <= 1'b1;
          st_q <= StOut;
        end
        StOut: if (!obusy_q) begin
          out_q <= {6'd0, critf_q, lowf_q, rt_q, req_q, led_q, spd_q, chgd_q,
                    mode_q, chg_q, pct_q, v_q, samp_q};
          obusy_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench for the battery power mode monitor
// Drives timestamped ADC beats through the input stream, predicts each result
// with an in-bench model of gate, voltage, percent, mode and runtime, and
// compares every output beat in full, with random stalls on both sides in most runs.
// ----------------------------------------------------------------------------
module tb_top
  import bpm_pkg::*;
();

  typedef struct packed {
    logic        crit_flag;
    logic        low_flag;
    logic [19:0] runtime_min;
    logic [1:0]  robot_request;
    logic [7:0]  led_level;
    logic [6:0]  speed_cap_pct;
    logic        mode_changed;
    logic [2:0]  mode;
    logic        charging;
    logic [6:0]  percent;
    logic [13:0] voltage_mv;
    logic        sampled;
  } monitor_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  battery_power_mode_monitor i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] p_min, p_max, p_low, p_crit, p_div;
  logic [31:0] p_last_t, p_intv, p_mode, p_lowf, p_critf, p_chg, p_prev;
  logic [31:0] p_refv, p_reft, p_rt, p_speed, p_led;

  monitor_out_t expected_q[$];
  logic [47:0]  beat_q[$];
  int errors = 0;
  int send_idle = 13, recv_idle = 62;

  function automatic monitor_out_t predict_sample(logic [11:0] adc, logic [31:0] now);
    monitor_out_t r;
    logic [63:0] num, est;
    logic [31:0] v, pct, m, req, dt;
    r = '0; v = 0; pct = 0; req = 0;
    if (now - p_last_t > p_intv) begin
      r.sampled = 1'b1;
      num = 64'(adc) * 3300 * 64'(p_div);
      num = num / (64'd4095 * 256);
      v = (num > 16383) ? 16383 : num[31:0];
      if (v >= p_max) pct = 100;
      else if (v <= p_min) pct = 0;
      else pct = (v - p_min) * 100 / (p_max - p_min);
      if (p_prev > 0 && v > p_prev + 100) p_chg = 1;
      else if (v + 50 < p_prev) p_chg = 0;
      p_prev = v;
      if (v <= p_min) m = ModeShutdown;
      else if (v <= p_crit) m = ModeCritical;
      else if (v <= p_low) m = ModeLow;
      else if (pct < 30) m = ModeEconomy;
      else m = ModeNormal;
      if (m != p_mode) begin
        r.mode_changed = 1'b1;
        case (m)
          ModeNormal: if (p_lowf || p_critf) begin
            p_lowf = 0; p_critf = 0; p_speed = 100; p_led = 255; p_intv = 2000;
            req = ReqIdle;
          end
          ModeEconomy: begin
            p_speed = 70; p_led = 128; p_intv = 5000;
          end
          ModeLow: begin
            p_lowf = 1; p_speed = 40; p_led = 64; p_intv = 10000; req = ReqSafe;
          end
          ModeCritical: begin
            p_critf = 1; p_speed = 20; p_led = 32; p_intv = 30000; req = ReqSafe;
          end
          default: req = ReqStop;
        endcase
        p_mode = m;
      end
      dt = now - p_reft;
      if (p_reft != 0 && p_refv != 0 && dt > 60000 && p_refv > v) begin
        est = 0;
        if (v > p_crit) est = (64'(v - p_crit) * 64'(dt)) / (64'(p_refv - v) * 60000);
        p_rt = (est > 1048575) ? 1048575 : est[31:0];
      end
      if (dt > 60000) begin
        p_refv = v; p_reft = now;
      end
      p_last_t = now;
    end
    r.voltage_mv = v[13:0];
    r.percent = pct[6:0];
    r.charging = p_chg[0];
    r.mode = p_mode[2:0];
    r.speed_cap_pct = p_speed[6:0];
    r.led_level = p_led[7:0];
    r.robot_request = req[1:0];
    r.runtime_min = p_rt[19:0];
    r.low_flag = p_lowf[0];
    r.crit_flag = p_critf[0];
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!s_axis_tvalid || s_axis_tready) begin
      if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk_i) begin
    monitor_out_t got, exp_r;
    if (s_axis_tvalid && s_axis_tready)
      expected_q.push_back(predict_sample(s_axis_tdata[11:0], s_axis_tdata[43:12]));
    if (m_axis_tvalid && m_axis_tready) begin
      got = monitor_out_t'(m_axis_tdata[65:0]);
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r || m_axis_tdata[71:66] !== 6'b0) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %p got %p", exp_r, got);
        end
      end
    end
  end

  logic [31:0] t_now = 0;

  task automatic queue_beat(logic [11:0] adc, logic [31:0] now);
    beat_q.push_back({4'b0, now, adc});
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [13:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMin:  p_min = 32'(val);
      RegMax:  p_max = 32'(val);
      RegLow:  p_low = 32'(val);
      RegCrit: p_crit = 32'(val);
      RegDiv:  p_div = 32'(val[10:0]);
      default: ;
    endcase
  endtask

  task automatic random_run(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: t_now = $urandom();
        1, 2: t_now = t_now + $urandom_range(3000);
        3: t_now = t_now + $urandom_range(70000);
        default: t_now = t_now + $urandom_range(1000, 32000);
      endcase
      if ($urandom_range(3) == 0) queue_beat(12'($urandom()), t_now);
      else queue_beat(12'(1500 + $urandom_range(1000)), t_now);
    end
  endtask

  initial begin
    p_min = 6000; p_max = 8400; p_low = 6800; p_crit = 6400; p_div = 512;
    p_last_t = 0; p_intv = 2000; p_mode = 0; p_lowf = 0; p_critf = 0; p_chg = 0;
    p_prev = 0; p_refv = 0; p_reft = 0; p_rt = 0; p_speed = 100; p_led = 255;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // directed: gate edge, extremes, every mode, charge swings, runtime
    queue_beat(12'd2000, 32'd2000);
    queue_beat(12'd2000, 32'd2001);
    queue_beat(12'd4095, 32'd5000);
    queue_beat(12'd0, 32'd8000);
    queue_beat(12'd1600, 32'd50000);
    queue_beat(12'd1700, 32'd90000);
    queue_beat(12'd1900, 32'd130000);
    queue_beat(12'd1800, 32'd200000);
    queue_beat(12'd1750, 32'd300000);
    queue_beat(12'd1720, 32'd400000);
    queue_beat(12'd1660, 32'd500000);
    queue_beat(12'd1580, 32'd600000);
    queue_beat(12'd2100, 32'd700000);
    queue_beat(12'd4095, 32'hFFFF_FFFF);
    queue_beat(12'd1000, 32'd40000);
    drain();
    // zero span, divider set to 1024
    write_reg(RegMin, 14'd7000);
    write_reg(RegMax, 14'd7000);
    write_reg(RegLow, 14'd0);
    write_reg(RegCrit, 14'd0);
    write_reg(RegDiv, 14'd1024);
    queue_beat(12'd1000, t_now + 32'd100000);
    queue_beat(12'd4095, t_now + 32'd200000);
    t_now = t_now + 32'd200000;
    random_run(100);
    drain();
    write_reg(RegMin, 14'd13200);
    write_reg(RegMax, 14'd16383);
    write_reg(RegLow, 14'd12000);
    write_reg(RegCrit, 14'd13200);
    write_reg(RegDiv, 14'd256);
    random_run(100);
    drain();
    write_reg(RegMin, 14'd6000);
    write_reg(RegMax, 14'd8400);
    write_reg(RegLow, 14'd6800);
    write_reg(RegCrit, 14'd6400);
    write_reg(RegDiv, 14'd512);
    write_reg(3'd7, 14'h3FFF);
    random_run(150);
    drain();
    send_idle = 62; recv_idle = 13;
    random_run(150);
    drain();
    send_idle = 0; recv_idle = 0;
    random_run(150);
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ----- battery_power_mode_monitor.f -----
design/bpm_pkg.sv
design/bpm_div.sv
design/battery_power_mode_monitor.sv
tb/tb_top.sv
